FILE: rtl/tlbm_pkg.sv
// tlbm_pkg: shared types, constants and the page mask decoder for the TLB
// maintenance unit. Used by tlbm_store, tlbm_match and tlb_maintenance_unit.
// Depends on nothing.
`default_nettype none

package tlbm_pkg;

	localparam int unsigned ENTRIES = 32;
	localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned VPN_LSB = 13;
	localparam int unsigned ASID_W  = 8;

	// page masks of the seven supported page sizes
	localparam logic [WORD_W-1:0] PM_4K   = 32'h0000_0000;
	localparam logic [WORD_W-1:0] PM_16K  = 32'h0000_6000;
	localparam logic [WORD_W-1:0] PM_64K  = 32'h0001_E000;
	localparam logic [WORD_W-1:0] PM_256K = 32'h0007_E000;
	localparam logic [WORD_W-1:0] PM_1M   = 32'h001F_E000;
	localparam logic [WORD_W-1:0] PM_4M   = 32'h007F_E000;
	localparam logic [WORD_W-1:0] PM_16M  = 32'h01FF_E000;

	typedef enum logic [1:0] {
		OP_PROBE     = 2'd0,
		OP_READ      = 2'd1,
		OP_WRITE_IDX = 2'd2,
		OP_WRITE_RND = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_READ,
		S_WRITE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo_even;
		logic [WORD_W-1:0] lo_odd;
		logic [WORD_W-1:0] mask;
	} entry_t;

	// true when the mask is one of the seven page sizes
	function automatic logic page_mask_known(input logic [WORD_W-1:0] pm);
		logic known;
		unique case (pm)
			PM_4K, PM_16K, PM_64K, PM_256K, PM_1M, PM_4M, PM_16M: known = 1'b1;
			default: known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tlbm_store.sv
// tlbm_store: entry memory with one write port, one registered read port
// and per-entry valid bits; an entry never written reads as zero.
// Depends on tlbm_pkg.
`default_nettype none

module tlbm_store (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [tlbm_pkg::ADDR_W-1:0]  wr_addr,
	input  wire tlbm_pkg::entry_t             wr_entry,
	input  wire logic                         rd_en,
	input  wire logic [tlbm_pkg::ADDR_W-1:0]  rd_addr,
	output tlbm_pkg::entry_t                  rd_entry
);

	tlbm_pkg::entry_t                 mem_q [tlbm_pkg::ENTRIES];
	tlbm_pkg::entry_t                 rd_data_q;
	logic [tlbm_pkg::ENTRIES-1:0]     valid_q;
	logic                             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/tlbm_match.sv
// tlbm_match: the shared probe comparator; checks one stored entry against
// the EntryHi key (VPN always, ASID unless the entry is global).
// Depends on tlbm_pkg.
`default_nettype none

module tlbm_match (
	input  wire tlbm_pkg::entry_t                  entry,
	input  wire logic [tlbm_pkg::WORD_W-1:0]       key_hi,
	output logic                                   hit
);

	logic vpn_eq;
	logic asid_eq;
	logic global_bit;

	assign vpn_eq     = entry.hi[tlbm_pkg::WORD_W-1:tlbm_pkg::VPN_LSB]
	                    == key_hi[tlbm_pkg::WORD_W-1:tlbm_pkg::VPN_LSB];
	assign asid_eq    = entry.hi[tlbm_pkg::ASID_W-1:0] == key_hi[tlbm_pkg::ASID_W-1:0];
	assign global_bit = entry.lo_even[0] & entry.lo_odd[0];
	assign hit        = vpn_eq & (global_bit | asid_eq);

endmodule

`default_nettype wire

FILE: rtl/tlb_maintenance_unit.sv
// tlb_maintenance_unit: probe, read and write of a MIPS-style TLB.
// Read and write pass through S_READ or S_WRITE and then S_EMIT; a probe scans
// from entry 0 and stops at the first hit or after the last entry, the single
// comparator stepping one entry a cycle through the one read port.
// One item at a time; the next input transfer is taken the cycle after the result
// is loaded, and the load waits while the previous result is held off.
// Reset (arst_n, async) clears all entries to zero via valid bits; no clearing pass.
`default_nettype none

module tlb_maintenance_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [tlbm_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [tlbm_pkg::IDX_W-1:0]        random_index,
	input  wire logic [tlbm_pkg::WORD_W-1:0]       entry_hi,
	input  wire logic [tlbm_pkg::WORD_W-1:0]       entry_lo_even,
	input  wire logic [tlbm_pkg::WORD_W-1:0]       entry_lo_odd,
	input  wire logic [tlbm_pkg::WORD_W-1:0]       page_mask,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   probe_miss,
	output logic [tlbm_pkg::IDX_W-1:0]             probe_index,
	output logic [tlbm_pkg::WORD_W-1:0]            read_page_mask,
	output logic [tlbm_pkg::WORD_W-1:0]            read_entry_hi,
	output logic [tlbm_pkg::WORD_W-1:0]            read_lo_even,
	output logic [tlbm_pkg::WORD_W-1:0]            read_lo_odd,
	output logic                                   bad_page_size
);

	tlbm_pkg::state_t                   state_q, state_d;
	tlbm_pkg::op_t                      op_in;
	tlbm_pkg::op_t                      op_q;
	logic [tlbm_pkg::IDX_W-1:0]         idx_sel;
	logic [tlbm_pkg::IDX_W-1:0]         idx_q;
	logic                               in_range_q;
	logic                               bad_q;
	logic [tlbm_pkg::WORD_W-1:0]        hi_q, lo_even_q, lo_odd_q, mask_q;

	logic [tlbm_pkg::ADDR_W-1:0]        scan_q, cmp_idx_q, hit_idx_q;
	logic                               cmp_vld_q, miss_q, last_cmp;

	logic                               accept, load;
	logic                               rd_en, wr_en, hit;
	logic [tlbm_pkg::ADDR_W-1:0]        rd_addr;
	tlbm_pkg::entry_t                   wr_entry, rd_entry;
	logic                               out_valid_q;
	logic                               read_g;

	logic                               probe_miss_q;
	logic [tlbm_pkg::IDX_W-1:0]         probe_index_q;
	logic [tlbm_pkg::WORD_W-1:0]        read_page_mask_q, read_entry_hi_q;
	logic [tlbm_pkg::WORD_W-1:0]        read_lo_even_q, read_lo_odd_q;
	logic                               bad_page_size_q;

	assign op_in   = tlbm_pkg::op_t'(op);
	assign idx_sel = (op_in == tlbm_pkg::OP_WRITE_RND) ? random_index : entry_index;
	assign accept  = in_valid & in_ready;
	assign last_cmp = cmp_idx_q == tlbm_pkg::ADDR_W'(tlbm_pkg::ENTRIES - 1);
	assign wr_entry = '{hi: hi_q, lo_even: lo_even_q, lo_odd: lo_odd_q, mask: mask_q};

	tlbm_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (idx_q[tlbm_pkg::ADDR_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	tlbm_match u_match (
		.entry  (rd_entry),
		.key_hi (hi_q),
		.hit    (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlbm_pkg::S_IDLE: begin
				if (accept) begin
					unique case (op_in)
						tlbm_pkg::OP_PROBE: state_d = tlbm_pkg::S_PROBE;
						tlbm_pkg::OP_READ:  state_d = tlbm_pkg::S_READ;
						default:            state_d = tlbm_pkg::S_WRITE;
					endcase
				end
			end
			tlbm_pkg::S_PROBE: begin
				if (cmp_vld_q && (hit || last_cmp)) begin
					state_d = tlbm_pkg::S_EMIT;
				end
			end
			tlbm_pkg::S_READ:  state_d = tlbm_pkg::S_EMIT;
			tlbm_pkg::S_WRITE: state_d = tlbm_pkg::S_EMIT;
			tlbm_pkg::S_EMIT: begin
				if (load) begin
					state_d = tlbm_pkg::S_IDLE;
				end
			end
			default: state_d = tlbm_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = scan_q;
		wr_en    = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			tlbm_pkg::S_IDLE:  in_ready = 1'b1;
			tlbm_pkg::S_PROBE: begin
				rd_en = {1'b0, scan_q} < (tlbm_pkg::ADDR_W + 1)'(tlbm_pkg::ENTRIES);
			end
			tlbm_pkg::S_READ: begin
				rd_en   = in_range_q;
				rd_addr = idx_q[tlbm_pkg::ADDR_W-1:0];
			end
			tlbm_pkg::S_WRITE: wr_en = in_range_q;
			tlbm_pkg::S_EMIT:  load  = ~out_valid_q | out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlbm_pkg::S_IDLE;
			cmp_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cmp_vld_q <= 1'b0;
			end else if (state_q == tlbm_pkg::S_PROBE) begin
				cmp_vld_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and probe scan position
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			idx_q      <= idx_sel;
			in_range_q <= {1'b0, idx_sel} < (tlbm_pkg::IDX_W + 1)'(tlbm_pkg::ENTRIES);
			bad_q      <= ~tlbm_pkg::page_mask_known(page_mask);
			hi_q       <= entry_hi;
			lo_even_q  <= entry_lo_even;
			lo_odd_q   <= entry_lo_odd;
			mask_q     <= page_mask;
			scan_q     <= '0;
			cmp_idx_q  <= '0;
		end else if (state_q == tlbm_pkg::S_PROBE) begin
			scan_q    <= scan_q + 1'b1;
			cmp_idx_q <= scan_q;
			if (cmp_vld_q && hit) begin
				miss_q    <= 1'b0;
				hit_idx_q <= cmp_idx_q;
			end else if (cmp_vld_q && last_cmp) begin
				miss_q    <= 1'b1;
				hit_idx_q <= '0;
			end
		end
	end

	assign read_g = rd_entry.lo_even[0] & rd_entry.lo_odd[0];

	// result register; fields of other ops stay zero
	always_ff @(posedge clk) begin
		if (load) begin
			probe_miss_q     <= (op_q == tlbm_pkg::OP_PROBE) & miss_q;
			probe_index_q    <= (op_q == tlbm_pkg::OP_PROBE)
			                    ? tlbm_pkg::IDX_W'(hit_idx_q) : '0;
			bad_page_size_q  <= (op_q == tlbm_pkg::OP_WRITE_IDX
			                     || op_q == tlbm_pkg::OP_WRITE_RND) & bad_q;
			if (op_q == tlbm_pkg::OP_READ && in_range_q) begin
				read_page_mask_q <= rd_entry.mask;
				read_entry_hi_q  <= rd_entry.hi & ~rd_entry.mask;
				read_lo_even_q   <= rd_entry.lo_even | tlbm_pkg::WORD_W'(read_g);
				read_lo_odd_q    <= rd_entry.lo_odd | tlbm_pkg::WORD_W'(read_g);
			end else begin
				read_page_mask_q <= '0;
				read_entry_hi_q  <= '0;
				read_lo_even_q   <= '0;
				read_lo_odd_q    <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign probe_miss     = probe_miss_q;
	assign probe_index    = probe_index_q;
	assign read_page_mask = read_page_mask_q;
	assign read_entry_hi  = read_entry_hi_q;
	assign read_lo_even   = read_lo_even_q;
	assign read_lo_odd    = read_lo_odd_q;
	assign bad_page_size  = bad_page_size_q;

`ifndef ASSERT_OFF
	a_wr_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (op_q == tlbm_pkg::OP_WRITE_IDX || op_q == tlbm_pkg::OP_WRITE_RND))
		else $error("store write outside a write op");
	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == tlbm_pkg::S_IDLE && out_valid_q))
		else $error("result load did not finish the item");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != tlbm_pkg::S_IDLE)
		else $error("accepted item did not start");
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && probe_miss_q) |-> probe_index_q == '0)
		else $error("probe miss with nonzero index");
`endif

endmodule

`default_nettype wire

FILE: tb/tlb_maintenance_checker.sv
// tlb_maintenance_checker: watches both channels of tlb_maintenance_unit, keeps its own
// copy of the TLB contents, predicts each response and compares it field by field.
// Depends on tlbm_pkg for widths, page mask constants and op codes.
`default_nettype none

module tlb_maintenance_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic [1:0]                  op,
	input  wire logic [tlbm_pkg::IDX_W-1:0]  entry_index,
	input  wire logic [tlbm_pkg::IDX_W-1:0]  random_index,
	input  wire logic [tlbm_pkg::WORD_W-1:0] entry_hi,
	input  wire logic [tlbm_pkg::WORD_W-1:0] entry_lo_even,
	input  wire logic [tlbm_pkg::WORD_W-1:0] entry_lo_odd,
	input  wire logic [tlbm_pkg::WORD_W-1:0] page_mask,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic                        probe_miss,
	input  wire logic [tlbm_pkg::IDX_W-1:0]  probe_index,
	input  wire logic [tlbm_pkg::WORD_W-1:0] read_page_mask,
	input  wire logic [tlbm_pkg::WORD_W-1:0] read_entry_hi,
	input  wire logic [tlbm_pkg::WORD_W-1:0] read_lo_even,
	input  wire logic [tlbm_pkg::WORD_W-1:0] read_lo_odd,
	input  wire logic                        bad_page_size,
	output int                               mismatch_count,
	output int                               results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tlbm_pkg::WORD_W-1:0] VPN_BITS  = 32'hFFFF_E000;
	localparam logic [tlbm_pkg::WORD_W-1:0] ASID_BITS = 32'h0000_00FF;

	typedef struct {
		logic                        miss;
		logic [tlbm_pkg::IDX_W-1:0]  hit_index;
		logic [tlbm_pkg::WORD_W-1:0] mask;
		logic [tlbm_pkg::WORD_W-1:0] hi;
		logic [tlbm_pkg::WORD_W-1:0] lo_even;
		logic [tlbm_pkg::WORD_W-1:0] lo_odd;
		logic                        bad_size;
	} tlb_result_t;

	logic [tlbm_pkg::WORD_W-1:0] hi_mem      [tlbm_pkg::ENTRIES];
	logic [tlbm_pkg::WORD_W-1:0] lo_even_mem [tlbm_pkg::ENTRIES];
	logic [tlbm_pkg::WORD_W-1:0] lo_odd_mem  [tlbm_pkg::ENTRIES];
	logic [tlbm_pkg::WORD_W-1:0] mask_mem    [tlbm_pkg::ENTRIES];
	logic [24:0]                 size_cmp_mem[tlbm_pkg::ENTRIES];
	logic                        written_mem [tlbm_pkg::ENTRIES];

	tlb_result_t awaited_results[$];
	tlb_result_t oldest;
	int          errors;

	// size compare value of the seven legal page masks
	function automatic logic decode_page_size(input logic [tlbm_pkg::WORD_W-1:0] pm,
		output logic [24:0] cmp);
		cmp = '0;
		case (pm)
			tlbm_pkg::PM_4K:   cmp = 25'h000_1000;
			tlbm_pkg::PM_16K:  cmp = 25'h000_4000;
			tlbm_pkg::PM_64K:  cmp = 25'h001_0000;
			tlbm_pkg::PM_256K: cmp = 25'h004_0000;
			tlbm_pkg::PM_1M:   cmp = 25'h010_0000;
			tlbm_pkg::PM_4M:   cmp = 25'h040_0000;
			tlbm_pkg::PM_16M:  cmp = 25'h100_0000;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic tlb_result_t apply_tlb_op(input tlbm_pkg::op_t code,
		input logic [tlbm_pkg::IDX_W-1:0] eidx, input logic [tlbm_pkg::IDX_W-1:0] ridx,
		input logic [tlbm_pkg::WORD_W-1:0] hi, input logic [tlbm_pkg::WORD_W-1:0] lo0,
		input logic [tlbm_pkg::WORD_W-1:0] lo1, input logic [tlbm_pkg::WORD_W-1:0] pm);
		tlb_result_t                 r;
		logic                        g;
		logic                        known;
		logic [24:0]                 cmp;
		logic [tlbm_pkg::IDX_W-1:0]  idx;
		r = '{default: '0};
		case (code)
			tlbm_pkg::OP_PROBE: begin
				r.miss = 1'b1;
				for (int i = 0; i < tlbm_pkg::ENTRIES; i++) begin
					g = lo_even_mem[i][0] & lo_odd_mem[i][0];
					if (r.miss && (hi_mem[i] & VPN_BITS) == (hi & VPN_BITS) &&
					    (g || (hi_mem[i] & ASID_BITS) == (hi & ASID_BITS))) begin
						r.miss      = 1'b0;
						r.hit_index = tlbm_pkg::IDX_W'(i);
					end
				end
			end
			tlbm_pkg::OP_READ: begin
				if (eidx < tlbm_pkg::ENTRIES) begin
					g         = lo_even_mem[eidx][0] & lo_odd_mem[eidx][0];
					r.mask    = mask_mem[eidx];
					r.hi      = hi_mem[eidx] & ~mask_mem[eidx];
					r.lo_even = lo_even_mem[eidx] | tlbm_pkg::WORD_W'(g);
					r.lo_odd  = lo_odd_mem[eidx] | tlbm_pkg::WORD_W'(g);
				end
			end
			default: begin
				idx   = (code == tlbm_pkg::OP_WRITE_IDX) ? eidx : ridx;
				known = decode_page_size(pm, cmp);
				if (idx < tlbm_pkg::ENTRIES) begin
					written_mem[idx] = 1'b1;
					mask_mem[idx]    = pm;
					hi_mem[idx]      = hi;
					lo_even_mem[idx] = lo0;
					lo_odd_mem[idx]  = lo1;
					// unknown mask keeps the old size compare value
					if (known)
						size_cmp_mem[idx] = cmp;
				end
				r.bad_size = !known;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string field, input logic [tlbm_pkg::WORD_W-1:0] want,
		input logic [tlbm_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tlbm_pkg::ENTRIES; i++) begin
				hi_mem[i]       = '0;
				lo_even_mem[i]  = '0;
				lo_odd_mem[i]   = '0;
				mask_mem[i]     = '0;
				size_cmp_mem[i] = '0;
				written_mem[i]  = 1'b0;
			end
			awaited_results.delete();
			errors = 0;
			mismatch_count  <= 0;
			results_pending <= 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(apply_tlb_op(tlbm_pkg::op_t'(op), entry_index,
					random_index, entry_hi, entry_lo_even, entry_lo_odd, page_mask));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result transfer expected none, actual miss %0b index %0d",
						$time, probe_miss, probe_index);
				end else begin
					oldest = awaited_results.pop_front();
					check_field("probe_miss", tlbm_pkg::WORD_W'(oldest.miss),
						tlbm_pkg::WORD_W'(probe_miss));
					check_field("probe_index", tlbm_pkg::WORD_W'(oldest.hit_index),
						tlbm_pkg::WORD_W'(probe_index));
					check_field("read_page_mask", oldest.mask, read_page_mask);
					check_field("read_entry_hi", oldest.hi, read_entry_hi);
					check_field("read_lo_even", oldest.lo_even, read_lo_even);
					check_field("read_lo_odd", oldest.lo_odd, read_lo_odd);
					check_field("bad_page_size", tlbm_pkg::WORD_W'(oldest.bad_size),
						tlbm_pkg::WORD_W'(bad_page_size));
				end
			end
			mismatch_count  <= errors;
			results_pending <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/tlb_maintenance_unit_tb.sv
// tlb_maintenance_unit_tb: drives directed and random probe, read and write transfers
// into tlb_maintenance_unit with random idling on both sides and gives the verdict.
// Depends on tlbm_pkg, the RTL and tlb_maintenance_checker.
`default_nettype none

module tlb_maintenance_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = tlbm_pkg::ENTRIES + 8;
	localparam logic [tlbm_pkg::WORD_W-1:0] PAGE_SIZES [7] =
		'{tlbm_pkg::PM_4K, tlbm_pkg::PM_16K, tlbm_pkg::PM_64K, tlbm_pkg::PM_256K,
		  tlbm_pkg::PM_1M, tlbm_pkg::PM_4M, tlbm_pkg::PM_16M};

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	tlbm_pkg::op_t               op;
	logic [tlbm_pkg::IDX_W-1:0]  entry_index;
	logic [tlbm_pkg::IDX_W-1:0]  random_index;
	logic [tlbm_pkg::WORD_W-1:0] entry_hi;
	logic [tlbm_pkg::WORD_W-1:0] entry_lo_even;
	logic [tlbm_pkg::WORD_W-1:0] entry_lo_odd;
	logic [tlbm_pkg::WORD_W-1:0] page_mask;
	logic                        out_valid;
	logic                        out_ready;
	logic                        probe_miss;
	logic [tlbm_pkg::IDX_W-1:0]  probe_index;
	logic [tlbm_pkg::WORD_W-1:0] read_page_mask;
	logic [tlbm_pkg::WORD_W-1:0] read_entry_hi;
	logic [tlbm_pkg::WORD_W-1:0] read_lo_even;
	logic [tlbm_pkg::WORD_W-1:0] read_lo_odd;
	logic                        bad_page_size;
	int                          mismatch_count;
	int                          results_pending;

	logic                        sender_idles;
	logic [tlbm_pkg::WORD_W-1:0] hi_pool [16];
	int                          pool_next;

	tlb_maintenance_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.entry_index    (entry_index),
		.random_index   (random_index),
		.entry_hi       (entry_hi),
		.entry_lo_even  (entry_lo_even),
		.entry_lo_odd   (entry_lo_odd),
		.page_mask      (page_mask),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.probe_miss     (probe_miss),
		.probe_index    (probe_index),
		.read_page_mask (read_page_mask),
		.read_entry_hi  (read_entry_hi),
		.read_lo_even   (read_lo_even),
		.read_lo_odd    (read_lo_odd),
		.bad_page_size  (bad_page_size)
	);

	tlb_maintenance_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.entry_index     (entry_index),
		.random_index    (random_index),
		.entry_hi        (entry_hi),
		.entry_lo_even   (entry_lo_even),
		.entry_lo_odd    (entry_lo_odd),
		.page_mask       (page_mask),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.probe_miss      (probe_miss),
		.probe_index     (probe_index),
		.read_page_mask  (read_page_mask),
		.read_entry_hi   (read_entry_hi),
		.read_lo_even    (read_lo_even),
		.read_lo_odd     (read_lo_odd),
		.bad_page_size   (bad_page_size),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one transfer and hold it until the block takes it
	task automatic offer(input tlbm_pkg::op_t code, input logic [tlbm_pkg::IDX_W-1:0] eidx,
		input logic [tlbm_pkg::IDX_W-1:0] ridx, input logic [tlbm_pkg::WORD_W-1:0] hi,
		input logic [tlbm_pkg::WORD_W-1:0] lo0, input logic [tlbm_pkg::WORD_W-1:0] lo1,
		input logic [tlbm_pkg::WORD_W-1:0] pm);
		if (sender_idles) begin
			while ($urandom_range(99) < 7) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		op            <= code;
		entry_index   <= eidx;
		random_index  <= ridx;
		entry_hi      <= hi;
		entry_lo_even <= lo0;
		entry_lo_odd  <= lo1;
		page_mask     <= pm;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (code == tlbm_pkg::OP_WRITE_IDX || code == tlbm_pkg::OP_WRITE_RND) begin
			hi_pool[pool_next] = hi;
			pool_next = (pool_next + 1) % 16;
		end
	endtask

	task automatic wait_for_results;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
	endtask

	// receiver: random stalls, one long hold-off, always ready outside the hold-off while the sender never idles
	initial begin
		int rx_cycle;
		rx_cycle  = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= 4000 && rx_cycle < 4400)
				out_ready <= 1'b0;
			else if (!sender_idles)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 7);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		tlbm_pkg::op_t               code;
		logic [tlbm_pkg::WORD_W-1:0] hi;
		logic [tlbm_pkg::WORD_W-1:0] lo0;
		logic [tlbm_pkg::WORD_W-1:0] lo1;
		logic [tlbm_pkg::WORD_W-1:0] pm;
		int                          pick;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = tlbm_pkg::OP_PROBE;
		entry_index   = '0;
		random_index  = '0;
		entry_hi      = '0;
		entry_lo_even = '0;
		entry_lo_odd  = '0;
		page_mask     = '0;
		sender_idles  = 1'b1;
		pool_next     = 0;
		for (int i = 0; i < 16; i++)
			hi_pool[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared store: VPN 0 / ASID 0 hits entry 0, all-ones misses
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'h0000_0000, 0, 0, 0);
		offer(tlbm_pkg::OP_PROBE, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		offer(tlbm_pkg::OP_READ, 0, 31, 0, 0, 0, 0);
		offer(tlbm_pkg::OP_READ, 31, 0, 0, 0, 0, 0);
		// every page size, global and non-global entries
		offer(tlbm_pkg::OP_WRITE_IDX, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			tlbm_pkg::PM_16M);
		offer(tlbm_pkg::OP_WRITE_RND, 0, 31, 32'hFFFF_E0AA, 32'h0000_0002, 32'h0000_0003,
			tlbm_pkg::PM_4K);
		offer(tlbm_pkg::OP_WRITE_IDX, 2, 9, 32'h1234_A055, 32'h0000_0001, 32'h0000_0000,
			tlbm_pkg::PM_16K);
		offer(tlbm_pkg::OP_WRITE_IDX, 3, 9, 32'h1234_A077, 32'h0000_0001, 32'h8000_0001,
			tlbm_pkg::PM_64K);
		offer(tlbm_pkg::OP_WRITE_RND, 9, 4, 32'h1234_A055, 32'h0000_0000, 32'h0000_0000,
			tlbm_pkg::PM_256K);
		offer(tlbm_pkg::OP_WRITE_IDX, 5, 0, 32'h0000_2005, 32'hAAAA_AAAA, 32'h5555_5555,
			tlbm_pkg::PM_1M);
		offer(tlbm_pkg::OP_WRITE_RND, 0, 6, 32'h0004_6006, 32'h5555_5555, 32'hAAAA_AAAA,
			tlbm_pkg::PM_4M);
		// unknown masks: stored anyway, flagged
		offer(tlbm_pkg::OP_WRITE_IDX, 7, 0, 32'h7000_0007, 32'h0000_0007, 32'h0000_0007,
			32'hFFFF_FFFF);
		offer(tlbm_pkg::OP_WRITE_IDX, 8, 0, 32'h8000_0008, 32'h0000_0008, 32'h0000_0008,
			32'h0000_2000);
		// lowest index wins; global entry ignores ASID; probe ignores page mask
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'h1234_A055, 0, 0, tlbm_pkg::PM_16M);
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'h1234_A099, 0, 0, 32'hFFFF_FFFF);
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'hFFFF_E000, 0, 0, 0);
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'hFFFF_E0AA, 0, 0, tlbm_pkg::PM_64K);
		offer(tlbm_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
		offer(tlbm_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
		offer(tlbm_pkg::OP_READ, 7, 0, 0, 0, 0, 0);
		offer(tlbm_pkg::OP_READ, 31, 0, 0, 0, 0, 0);
		offer(tlbm_pkg::OP_WRITE_IDX, 0, 0, 32'h8000_0000, 0, 0, tlbm_pkg::PM_4K);
		offer(tlbm_pkg::OP_WRITE_RND, 0, 1, 32'hFFFF_E011, 32'h0000_0000, 32'h0000_0001,
			tlbm_pkg::PM_4K);
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'hFFFF_E0AA, 0, 0, 0);
		offer(tlbm_pkg::OP_PROBE, 0, 0, 32'hFFFF_E0AB, 0, 0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_idles = !(n >= 700 && n < 1000);
			if (n == 1200)
				wait_for_results();
			pick = $urandom_range(99);
			code = (pick < 35) ? tlbm_pkg::OP_PROBE : (pick < 60) ? tlbm_pkg::OP_READ :
				(pick < 80) ? tlbm_pkg::OP_WRITE_IDX : tlbm_pkg::OP_WRITE_RND;
			pick = $urandom_range(99);
			if (code == tlbm_pkg::OP_PROBE) begin
				// mostly look up something already written
				if (pick < 60) begin
					hi = hi_pool[$urandom_range(15)];
					if ($urandom_range(1))
						hi[7:0] = 8'($urandom);
				end else
					hi = $urandom;
			end else if (pick < 40)
				hi = $urandom;
			else if (pick < 70) begin
				hi = hi_pool[$urandom_range(15)];
				hi[7:0] = 8'($urandom);
			end else
				hi = {19'($urandom_range(15)), 13'($urandom)};
			lo0 = $urandom;
			lo1 = $urandom;
			if ($urandom_range(99) < 30) begin
				lo0[0] = 1'b1;
				lo1[0] = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 70)
				pm = PAGE_SIZES[$urandom_range(6)];
			else if (pick < 85)
				pm = $urandom;
			else
				pm = PAGE_SIZES[$urandom_range(6)] ^ (32'h1 << $urandom_range(31));
			offer(code, tlbm_pkg::IDX_W'($urandom), tlbm_pkg::IDX_W'($urandom), hi, lo0,
				lo1, pm);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: tlb_maintenance_unit.f
rtl/tlbm_pkg.sv
rtl/tlbm_store.sv
rtl/tlbm_match.sv
rtl/tlb_maintenance_unit.sv
tb/tlb_maintenance_checker.sv
tb/tlb_maintenance_unit_tb.sv
